// File: design/per_symbol_trade_statistics_defines.svh
// Assertion macros shared by the block's modules.
`ifndef PER_SYMBOL_TRADE_STATISTICS_DEFINES_SVH
`define PER_SYMBOL_TRADE_STATISTICS_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PSTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the following cycle.
`define PSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/psts_pkg.sv
`default_nettype none
package psts_pkg;

    localparam int Entries = 64;
    localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;

    // Result status codes.
    localparam logic [1:0] StTrade   = 2'd0;
    localparam logic [1:0] StHit     = 2'd1;
    localparam logic [1:0] StUnknown = 2'd2;
    localparam logic [1:0] StFull    = 2'd3;

    localparam logic CmdTrade = 1'b0;
    localparam logic CmdQuery = 1'b1;

    typedef struct packed {
        logic               command;
        logic        [63:0] symbol_key;
        logic        [63:0] trade_time;
        logic signed [31:0] quantity;
        logic signed [31:0] price;
    } req_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [63:0] largest_gap;
        logic signed [63:0] volume_sum;
        logic signed [31:0] average_price;
        logic signed [31:0] highest_price;
        logic               zero_volume;
    } resp_t;

    // One table entry as held in the statistics memory.
    typedef struct packed {
        logic [63:0] last_time;
        logic [63:0] max_gap;
        logic [63:0] volume;
        logic [63:0] wsum;
        logic [31:0] peak_price;
    } stats_t;

    localparam int StatsW = $bits(stats_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_DECIDE,
        S_READ,
        S_MUL,
        S_UPDATE,
        S_DIV_START,
        S_DIV,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

// File: design/psts_ram.sv
`default_nettype none
module psts_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                             clk,
    input  wire                             we,
    input  wire  [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr,
    input  wire  [Width-1:0]                wdata,
    input  wire  [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr,
    output logic [Width-1:0]                rdata
);

    logic [Width-1:0] mem [Depth];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: design/psts_div.sv
`default_nettype none
`include "per_symbol_trade_statistics_defines.svh"
module psts_div (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  wire        [63:0] dividend,
    input  wire        [63:0] divisor,
    output logic       [31:0] quotient,
    output logic              busy,
    output logic              done
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    // Restoring division on magnitudes, one quotient bit per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[63]};
        trial     = shifted - {1'b0, den_reg};
        if (start)
        begin
            neg_next  = dividend[63] ^ divisor[63];
            quo_next  = dividend[63] ? (~dividend + 64'd1) : dividend;
            den_next  = divisor[63] ? (~divisor + 64'd1) : divisor;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Sign correction and saturation to 32 bits.
    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg >= 64'h8000_0000)
            begin
                quotient = 32'h8000_0000;
            end
            else
            begin
                quotient = 32'd0 - quo_reg[31:0];
            end
        end
        else if (quo_reg > 64'h7FFF_FFFF)
        begin
            quotient = 32'h7FFF_FFFF;
        end
        else
        begin
            quotient = quo_reg[31:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `PSTS_ASSERT_IMP(a_done_not_busy, clk, rst_n, done_reg, !busy_reg)
    `PSTS_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_reg)
    `PSTS_ASSERT_IMP(a_cnt_range, clk, rst_n, busy_reg, cnt_reg != 7'd0)

endmodule
`default_nettype wire

// File: design/per_symbol_trade_statistics.sv
// Per-symbol trade statistics.
// Requests arrive on req (valid/ready) as psts_pkg::req_t; each gives one
// response on resp (valid/ready) as psts_pkg::resp_t. A trade finds its
// symbol or allocates the lowest free entry (StFull if none is free),
// then updates gap, volume, weighted sum and highest price; a query
// returns the stored figures (StUnknown for a symbol not in the table).
// One request is handled at a time. The key search reads the key memory
// one entry a cycle; an entry that is found or allocated is then read
// and, for a trade, rewritten, and where its volume sum is not zero the
// one-bit-a-cycle divider forms the average price before the response.
// Once the response is taken the block returns to idle and accepts the
// next request. Reset clears the used bits (flip-flops) and the control;
// the memories need no clearing. A finished response is held in an output
// register until taken; the next request is accepted only once the
// response has gone, so a stalled receiver simply holds the block.
`default_nettype none
`include "per_symbol_trade_statistics_defines.svh"
module per_symbol_trade_statistics (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    output logic              req_ready,
    input  psts_pkg::req_t    req,
    output logic              resp_valid,
    input  wire               resp_ready,
    output psts_pkg::resp_t   resp
);

    localparam int IdxW = psts_pkg::IdxW;

    psts_pkg::state_t state_reg, state_next;
    psts_pkg::req_t   req_reg;
    psts_pkg::resp_t  resp_reg, resp_next;
    psts_pkg::stats_t st_reg, st_next;
    psts_pkg::stats_t st_rd;
    logic             div_start;
    logic             div_busy;
    logic             div_done;

    logic [psts_pkg::Entries-1:0] used_reg;
    logic [IdxW-1:0] scan_reg, scan_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic            found_reg, found_next;
    logic [IdxW-1:0] free_reg, free_next;
    logic            free_ok_reg, free_ok_next;
    logic            new_reg, new_next;
    logic [63:0]     key_rd;
    logic [63:0]     prod_reg;
    logic [31:0]     div_q;
    logic            key_we, st_we;
    logic [IdxW-1:0] cmp_idx_reg;
    logic            cmp_ok_reg;
    logic [63:0]     gap;

    // Key memory searched one entry a cycle; statistics memory read and rewritten.
    psts_ram #(.Width(64), .Depth(psts_pkg::Entries)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(free_reg), .wdata(req_reg.symbol_key),
        .raddr(scan_reg), .rdata(key_rd)
    );

    psts_ram #(.Width(psts_pkg::StatsW), .Depth(psts_pkg::Entries)) u_stats_ram (
        .clk(clk), .we(st_we), .waddr(idx_reg), .wdata(st_reg),
        .raddr(idx_reg), .rdata(st_rd)
    );

    psts_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(st_reg.wsum), .divisor(st_reg.volume),
        .quotient(div_q), .busy(div_busy), .done(div_done)
    );

    assign req_ready  = (state_reg == psts_pkg::S_IDLE);
    assign resp_valid = (state_reg == psts_pkg::S_OUT);
    assign resp       = resp_reg;
    assign gap        = req_reg.trade_time - st_reg.last_time;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psts_pkg::S_IDLE:
                if (req_valid) state_next = psts_pkg::S_SCAN;
            psts_pkg::S_SCAN:
                if (scan_reg == IdxW'(psts_pkg::Entries - 1))
                    state_next = psts_pkg::S_SCAN_LAST;
            psts_pkg::S_SCAN_LAST:
                state_next = psts_pkg::S_DECIDE;
            psts_pkg::S_DECIDE:
                if (found_reg || (req_reg.command == psts_pkg::CmdTrade && free_ok_reg))
                    state_next = psts_pkg::S_READ;
                else
                    state_next = psts_pkg::S_OUT;
            psts_pkg::S_READ:
                state_next = psts_pkg::S_MUL;
            psts_pkg::S_MUL:
                state_next = (req_reg.command == psts_pkg::CmdTrade)
                           ? psts_pkg::S_UPDATE : psts_pkg::S_DIV_START;
            psts_pkg::S_UPDATE:
                state_next = psts_pkg::S_DIV_START;
            psts_pkg::S_DIV_START:
                state_next = (st_reg.volume == 64'd0) ? psts_pkg::S_OUT : psts_pkg::S_DIV;
            psts_pkg::S_DIV:
                if (div_done) state_next = psts_pkg::S_OUT;
            psts_pkg::S_OUT:
                if (resp_ready) state_next = psts_pkg::S_IDLE;
            default:
                state_next = psts_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs of each state.
    always_comb
    begin
        scan_next    = scan_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        free_next    = free_reg;
        free_ok_next = free_ok_reg;
        new_next     = new_reg;
        st_next      = st_reg;
        resp_next    = resp_reg;
        key_we       = 1'b0;
        st_we        = 1'b0;
        div_start    = 1'b0;
        unique case (state_reg)
            psts_pkg::S_IDLE:
            begin
                scan_next    = '0;
                found_next   = 1'b0;
                free_ok_next = 1'b0;
            end
            psts_pkg::S_SCAN, psts_pkg::S_SCAN_LAST:
            begin
                if (state_reg == psts_pkg::S_SCAN
                    && scan_reg != IdxW'(psts_pkg::Entries - 1))
                    scan_next = scan_reg + IdxW'(1);
                // Compare the key read in the previous cycle.
                if (cmp_ok_reg)
                begin
                    if (used_reg[cmp_idx_reg])
                    begin
                        if (!found_reg && key_rd == req_reg.symbol_key)
                        begin
                            found_next = 1'b1;
                            idx_next   = cmp_idx_reg;
                        end
                    end
                    else if (!free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = cmp_idx_reg;
                    end
                end
            end
            psts_pkg::S_DECIDE:
            begin
                new_next = !found_reg;
                if (!found_reg) idx_next = free_reg;
                resp_next = '0;
                if (!found_reg)
                    resp_next.status = (req_reg.command == psts_pkg::CmdQuery)
                                     ? psts_pkg::StUnknown : psts_pkg::StFull;
                if (!found_reg && req_reg.command == psts_pkg::CmdTrade && free_ok_reg)
                    key_we = 1'b1;
            end
            psts_pkg::S_READ:
            begin
            end
            psts_pkg::S_MUL:
            begin
                if (new_reg) st_next = '0;
                else st_next = st_rd;
            end
            psts_pkg::S_UPDATE:
            begin
                if (st_reg.last_time != 64'd0 && gap > st_reg.max_gap)
                    st_next.max_gap = gap;
                st_next.last_time = req_reg.trade_time;
                st_next.volume = st_reg.volume + 64'(signed'(req_reg.quantity));
                st_next.wsum   = st_reg.wsum + prod_reg;
                if (req_reg.price > signed'(st_reg.peak_price))
                    st_next.peak_price = req_reg.price;
            end
            psts_pkg::S_DIV_START:
            begin
                if (req_reg.command == psts_pkg::CmdTrade) st_we = 1'b1;
                resp_next.status = (req_reg.command == psts_pkg::CmdTrade)
                                 ? psts_pkg::StTrade : psts_pkg::StHit;
                resp_next.largest_gap   = st_reg.max_gap;
                resp_next.volume_sum    = st_reg.volume;
                resp_next.highest_price = st_reg.peak_price;
                resp_next.zero_volume   = (st_reg.volume == 64'd0);
                resp_next.average_price = '0;
                div_start = (st_reg.volume != 64'd0);
            end
            psts_pkg::S_DIV:
            begin
                if (div_done) resp_next.average_price = div_q;
            end
            psts_pkg::S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= psts_pkg::S_IDLE;
            used_reg    <= '0;
            cmp_ok_reg  <= 1'b0;
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_ok_reg  <= (state_reg == psts_pkg::S_SCAN);
            found_reg   <= found_next;
            free_ok_reg <= free_ok_next;
            if (key_we) used_reg[free_reg] <= 1'b1;
        end
    end

    // Payload registers; the full 64-bit product is formed while the entry is read.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready) req_reg <= req;
        scan_reg    <= scan_next;
        cmp_idx_reg <= scan_reg;
        idx_reg     <= idx_next;
        free_reg    <= free_next;
        new_reg     <= new_next;
        st_reg      <= st_next;
        resp_reg    <= resp_next;
        prod_reg    <= 64'(req_reg.quantity) * 64'(req_reg.price);
    end

    `PSTS_ASSERT_IMP(a_ready_no_resp, clk, rst_n, req_ready, !resp_valid)
    `PSTS_ASSERT_NEXT(a_hold_resp, clk, rst_n, resp_valid && !resp_ready, resp_valid)
    `PSTS_ASSERT_IMP(a_div_in_div, clk, rst_n, div_busy, state_reg == psts_pkg::S_DIV)
    `PSTS_ASSERT_IMP(a_found_used, clk, rst_n,
        state_reg == psts_pkg::S_DECIDE && found_reg, used_reg[idx_reg])

endmodule
`default_nettype wire
